### rtl/core/jpp_pkg.sv
package jpp_pkg;

  // Packet delimiters and the digit base
  localparam logic [7:0] CHAR_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CHAR_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0', also the mode offset
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;  // first of the control whitespace run
  localparam logic [7:0] CHAR_CR    = 8'h0D;  // last of the control whitespace run

  // Configuration register map
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam logic        REG_FREE_MODE = 1'b0;   // word index of free_mode_code
  localparam logic [7:0]  FREE_MODE_RST = 8'd1;

  // Widths of the result word
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned MODE_W     = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // Conversion phase of the field being collected
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,   // skipping leading whitespace
    PH_SIGN   = 2'd1,   // sign taken, digits expected
    PH_DIGITS = 2'd2,   // inside the digit run
    PH_STOP   = 2'd3    // conversion finished
  } field_phase_t;

  // Per-byte control from the decoder to the field unit
  typedef struct packed {
    logic       take;      // store one character of the field
    logic       clear;     // restart the field empty
    logic [7:0] rx_byte;
  } field_ctl_t;

endpackage

### rtl/core/jpp_regs.sv
module jpp_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [jpp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  output logic [jpp_pkg::MODE_W-1:0]       free_mode
);
  import jpp_pkg::*;

  logic [MODE_W-1:0] free_mode_r;
  logic              wr_en;
  logic              reg_idx;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (reg_idx == REG_FREE_MODE);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_mode_r <= FREE_MODE_RST;
    end else if (wr_en) begin
      free_mode_r <= cfg_pwdata[MODE_W-1:0];
    end
  end

  // readback
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_FREE_MODE) begin
      cfg_prdata = {{(32-MODE_W){1'b0}}, free_mode_r};
    end
  end

  assign free_mode = free_mode_r;

endmodule

### rtl/core/jpp_field.sv
module jpp_field #(
  parameter int unsigned FIELD_CHARS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jpp_pkg::field_ctl_t          ctl,
  output logic [jpp_pkg::AXIS_W-1:0]   value
);
  import jpp_pkg::*;

  localparam int unsigned CNT_W = (FIELD_CHARS > 2) ? $clog2(FIELD_CHARS) : 1;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [AXIS_W-1:0] acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  field_phase_t      phase_r, phase_nxt;

  logic              is_digit;
  logic              is_space;
  logic [3:0]        digit;
  logic [AXIS_W-1:0] acc_x10;
  logic [CNT_W:0]    count_inc;

  // character classes
  assign is_digit = (ctl.rx_byte >= CHAR_ZERO) && (ctl.rx_byte <= CHAR_NINE);
  assign is_space = (ctl.rx_byte == CHAR_SPACE) ||
                    ((ctl.rx_byte >= CHAR_TAB) && (ctl.rx_byte <= CHAR_CR));
  assign digit    = 4'(ctl.rx_byte - CHAR_ZERO);

  // acc * 10 as two shifts, wrapping in 16 bits
  assign acc_x10   = (acc_r << 3) + (acc_r << 1);
  assign count_inc = {1'b0, count_r} + 1'b1;

  // one conversion step per stored character
  always_comb begin
    count_nxt = count_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    if (ctl.clear) begin
      count_nxt = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      phase_nxt = PH_SPACE;
    end else if (ctl.take) begin
      unique case (phase_r)
        PH_SPACE: begin
          priority if (is_space) begin
            phase_nxt = PH_SPACE;
          end else if (ctl.rx_byte == CHAR_PLUS) begin
            phase_nxt = PH_SIGN;
          end else if (ctl.rx_byte == CHAR_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGN;
          end else if (is_digit) begin
            acc_nxt   = {{(AXIS_W-4){1'b0}}, digit};
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) begin
            acc_nxt   = acc_x10 + {{(AXIS_W-4){1'b0}}, digit};
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_STOP: begin
          phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
      // buffer full: the field restarts empty
      if (count_inc >= (CNT_W+1)'(FIELD_CHARS)) begin
        count_nxt = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PH_SPACE;
      end else begin
        count_nxt = count_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= PH_SPACE;
    end else begin
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
    end
  end

  // signed value of the field so far
  assign value = neg_r ? (AXIS_W'(0) - acc_r) : acc_r;

endmodule

### rtl/core/joystick_packet_parser.sv
// Joystick packet parser.
// Bytes of a serial stream enter on the in_ channel, one byte per word in
// in_tdata[7:0]. Packets of the form <x,y> set the x and y axes by a decimal
// conversion with optional whitespace and sign, wrapping in 16 bits. A byte
// outside a packet that is not '<', ',' or '>' sets the mode to byte minus
// 48 and raises mode_ack; x and y are cleared unless that mode equals the
// free_mode_code register. Every accepted byte gives exactly one word on the
// out_ channel carrying the axes, mode and ack after that byte.
// An accepted byte is held in the input register, and its result goes into
// the output register once that register is free. Throughput is one byte per
// cycle while out_tready is high; the single conversion step (multiply by ten
// and add) sits between those two registers.
// When out_tready is low the result word holds, the input register holds
// one more byte, and in_tready then drops until the output drains.
// Reset (rst_n low, synchronous) empties both registers, clears the parser
// state, the axes and the mode, and sets free_mode_code to 1.
// The free_mode_code register sits at byte address 0 of the cfg_ port.
module joystick_packet_parser #(
  parameter int unsigned FIELD_CHARS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  // out_tdata: [15:0] x_axis, [31:16] y_axis, [39:32] mode_value,
  //            [40] mode_ack, [47:41] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [jpp_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [jpp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import jpp_pkg::*;

  logic [MODE_W-1:0] free_mode;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_free;
  logic       proc_fire;

  // parser state
  logic              collecting_r, collecting_nxt;
  logic [AXIS_W-1:0] x_r, x_nxt;
  logic [AXIS_W-1:0] y_r, y_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              ack_nxt;
  logic [AXIS_W-1:0] field_value;
  field_ctl_t        fctl;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic is_open, is_comma, is_close;

  jpp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .free_mode   (free_mode)
  );

  // pipeline flow
  assign out_free  = !out_valid_r || out_tready;
  assign proc_fire = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // byte decode
  assign is_open  = (in_byte_r == CHAR_OPEN);
  assign is_comma = (in_byte_r == CHAR_COMMA);
  assign is_close = (in_byte_r == CHAR_CLOSE);

  assign fctl.rx_byte = in_byte_r;
  assign fctl.clear   = proc_fire && (is_comma || is_close);
  assign fctl.take    = proc_fire && collecting_r && !is_open && !is_comma && !is_close;

  jpp_field #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_field (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fctl),
    .value (field_value)
  );

  // axis and mode update
  always_comb begin
    collecting_nxt = collecting_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    mode_nxt       = mode_r;
    ack_nxt        = 1'b0;
    priority if (is_open) begin
      collecting_nxt = 1'b1;
    end else if (is_comma) begin
      x_nxt = field_value;
    end else if (is_close) begin
      y_nxt          = field_value;
      collecting_nxt = 1'b0;
    end else if (collecting_r) begin
      ack_nxt = 1'b0;
    end else begin
      mode_nxt = in_byte_r - CHAR_ZERO;
      ack_nxt  = 1'b1;
      if (mode_nxt != free_mode) begin
        x_nxt = '0;
        y_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
      mode_r       <= '0;
    end else if (proc_fire) begin
      collecting_r <= collecting_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      mode_r       <= mode_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_data_r <= {{(OUT_DATA_W-2*AXIS_W-MODE_W-1){1'b0}},
                     ack_nxt, mode_nxt, y_nxt, x_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a processed byte always leaves a result word behind
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |=> out_valid_r)
    else $error("processed byte produced no result word");

  // the input side only stalls behind a held byte
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a held byte");

  // a mode change away from free mode clears both axes
  a_mode_clears_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && ack_nxt && (mode_nxt != free_mode)) |=>
      (out_data_r[2*AXIS_W-1:0] == '0))
    else $error("axes not cleared on mode change");

  // the result word mirrors the parser state it was taken from
  a_word_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |=> (out_data_r[AXIS_W-1:0] == x_r) &&
                  (out_data_r[2*AXIS_W-1:AXIS_W] == y_r) &&
                  (out_data_r[2*AXIS_W+MODE_W-1:2*AXIS_W] == mode_r))
    else $error("result word differs from parser state");

endmodule

### tb/joystick_packet_parser_tb.sv
`timescale 1ns / 100ps

module joystick_packet_parser_tb;
  import jpp_pkg::*;

  localparam int FIELD_LEN   = 10;
  localparam int PHASE_BYTES = 155;
  localparam int PHASES      = 7;

  // One result word, split into its fields
  typedef struct packed {
    logic       ack;
    logic [7:0] mode;
    logic [15:0] y;
    logic [15:0] x;
  } axes_word_t;

  // Tracks the parser state and checks every result word in order
  class axes_scoreboard;
    logic [7:0]   free_mode;
    bit           collecting;
    logic [3:0]   char_count;
    logic [15:0]  acc;
    bit           negative;
    field_phase_t phase;
    logic [15:0]  x_val;
    logic [15:0]  y_val;
    logic [7:0]   mode_val;
    axes_word_t   expected_axes[$];
    int           mismatches;

    function new();
      free_mode  = FREE_MODE_RST;
      collecting = 1'b0;
      x_val      = '0;
      y_val      = '0;
      mode_val   = '0;
      mismatches = 0;
      clear_field();
    endfunction

    function void clear_field();
      char_count = '0;
      acc        = '0;
      negative   = 1'b0;
      phase      = PH_SPACE;
    endfunction

    function logic [15:0] field_result();
      return negative ? 16'(16'd0 - acc) : acc;
    endfunction

    // atoi-style conversion, one character at a time
    function void take_char(logic [7:0] c);
      bit is_digit;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      case (phase)
        PH_SPACE: begin
          if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            // leading whitespace is skipped
          end else if (c == CHAR_PLUS) begin
            phase = PH_SIGN;
          end else if (c == CHAR_MINUS) begin
            negative = 1'b1;
            phase    = PH_SIGN;
          end else if (is_digit) begin
            acc   = 16'(c - CHAR_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_STOP;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) begin
            acc   = 16'(acc * 16'd10 + 16'(c - CHAR_ZERO));
            phase = PH_DIGITS;
          end else begin
            phase = PH_STOP;
          end
        end
        default: begin
        end
      endcase
      // field restarts once it fills the buffer
      if (int'(char_count) + 1 >= FIELD_LEN) clear_field();
      else char_count = char_count + 4'd1;
    endfunction

    // Accepted input byte: advance state, queue the word it produces
    function void note_rx_byte(logic [7:0] c);
      axes_word_t w;
      bit ack;
      ack = 1'b0;
      if (c == CHAR_OPEN) begin
        collecting = 1'b1;
      end else if (c == CHAR_COMMA) begin
        x_val = field_result();
        clear_field();
      end else if (c == CHAR_CLOSE) begin
        y_val = field_result();
        clear_field();
        collecting = 1'b0;
      end else if (collecting) begin
        take_char(c);
      end else begin
        mode_val = 8'(c - CHAR_ZERO);
        if (mode_val != free_mode) begin
          x_val = '0;
          y_val = '0;
        end
        ack = 1'b1;
      end
      w.x    = x_val;
      w.y    = y_val;
      w.mode = mode_val;
      w.ack  = ack;
      expected_axes.push_back(w);
    endfunction

    function void check_axes_word(logic [OUT_DATA_W-1:0] d);
      axes_word_t e;
      if (expected_axes.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, d);
        mismatches++;
        return;
      end
      e = expected_axes.pop_front();
      if (d[15:0] !== e.x) begin
        $display("%0t: x_axis expected %h actual %h", $time, e.x, d[15:0]);
        mismatches++;
      end
      if (d[31:16] !== e.y) begin
        $display("%0t: y_axis expected %h actual %h", $time, e.y, d[31:16]);
        mismatches++;
      end
      if (d[39:32] !== e.mode) begin
        $display("%0t: mode_value expected %h actual %h", $time, e.mode, d[39:32]);
        mismatches++;
      end
      if (d[40] !== e.ack) begin
        $display("%0t: mode_ack expected %b actual %b", $time, e.ack, d[40]);
        mismatches++;
      end
      if (d[47:41] !== '0) begin
        $display("%0t: pad bits expected 00 actual %h", $time, d[47:41]);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;      // [7:0] rx_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;          // [15:0] x, [31:16] y, [39:32] mode, [40] ack
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  axes_scoreboard sb;
  logic [7:0]     rx_stream[$];
  bit             in_quiet = 1'b0;
  bit             out_quiet = 1'b0;

  joystick_packet_parser #(.FIELD_CHARS(FIELD_LEN)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // One numeric field: whitespace, sign, digits, sometimes junk or an overlong run
  function automatic void push_field();
    int kind;
    int n;
    int r;
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      n = $urandom_range(FIELD_LEN - 1, FIELD_LEN + 5);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) rx_stream.push_back(CHAR_SPACE);
        else rx_stream.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) begin
        r = $urandom_range(0, 5);
        rx_stream.push_back((r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r));
      end
      case ($urandom_range(0, 3))
        1: rx_stream.push_back(CHAR_PLUS);
        2: rx_stream.push_back(CHAR_MINUS);
        default: begin
        end
      endcase
      n = (kind == 1) ? 0 : ((kind <= 3) ? $urandom_range(5, 8) : $urandom_range(1, 4));
      repeat (n) rx_stream.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if (kind == 11) rx_stream.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Send one byte, with a random gap before it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_rx_byte(b);
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
  endtask

  // Register write: a setup phase, then an access phase
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Result side: random stall before each word, then check it
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = draw_wait(out_quiet);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_axes_word(out_tdata);
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
    end
  end

  // Stimulus: directed bytes, then packet-shaped random traffic per mode setting
  initial begin
    string      opening;
    logic [7:0] code;
    int         r;
    sb = new();
    opening = "1< -32768<,+99999999999>,";
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: code = 8'h00;
          2: code = 8'hFF;
          4: code = 8'd5;
          6: code = FREE_MODE_RST;
          default: code = 8'($urandom_range(0, 255));
        endcase
        cfg_write(CFG_ADDR_W'(4 * REG_FREE_MODE), {24'd0, code});
        sb.free_mode = code;
      end
      rx_stream.delete();
      if (p == 0) begin
        // mode into free, sign, wrap, open inside a packet, field restart,
        // comma outside a packet, byte extremes
        for (int i = 0; i < opening.len(); i++) rx_stream.push_back(opening[i]);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h00);
      end
      while (rx_stream.size() < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
        end else if (r <= 2) begin
          case ($urandom_range(0, 2))
            0: rx_stream.push_back(8'(sb.free_mode + CHAR_ZERO));
            1: rx_stream.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            default: rx_stream.push_back(8'($urandom_range(0, 255)));
          endcase
        end else begin
          // mostly complete packets, a few missing a delimiter
          r = $urandom_range(0, 9);
          rx_stream.push_back(CHAR_OPEN);
          push_field();
          if (r != 0) rx_stream.push_back(CHAR_COMMA);
          push_field();
          if (r != 1) rx_stream.push_back(CHAR_CLOSE);
        end
      end
      foreach (rx_stream[i]) send_byte(rx_stream[i]);
      in_tvalid <= 1'b0;
      while (sb.expected_axes.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### joystick_packet_parser.f
rtl/core/jpp_pkg.sv
rtl/core/jpp_regs.sv
rtl/core/jpp_field.sv
rtl/core/joystick_packet_parser.sv
tb/joystick_packet_parser_tb.sv
